>>> src/twrl_pkg.sv
package twrl_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_LIMIT = 2'd1;

  localparam logic [LIMIT_W-1:0] SECOND_LIMIT_RST = 7'd8;
  localparam logic [LIMIT_W-1:0] MINUTE_LIMIT_RST = 7'd64;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PURGE,
    ST_CHECK,
    ST_COUNT
  } state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] sec_lim;
    logic [LIMIT_W-1:0] min_lim;
  } limits_t;

endpackage

>>> src/twrl_ram.sv
module twrl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/twrl_seq.sv
module twrl_seq #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned SECOND_MS  = 1000,
  parameter int unsigned MINUTE_MS  = 60000
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  start_i,
  input  logic                                                  op_i,
  input  logic [twrl_pkg::TIME_W-1:0]                           now_ms_i,
  input  twrl_pkg::limits_t                                     limits_i,
  output logic                                                  busy_o,
  output logic                                                  done_o,
  output logic                                                  granted_o,
  output logic                                                  ram_we_o,
  output logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] ram_waddr_o,
  output logic [twrl_pkg::TIME_W-1:0]                           ram_wdata_o,
  output logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] ram_raddr_o,
  input  logic [twrl_pkg::TIME_W-1:0]                           ram_rdata_i
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned LW = (CW > twrl_pkg::LIMIT_W) ? CW : twrl_pkg::LIMIT_W;
  localparam int unsigned TW = twrl_pkg::TIME_W;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(RING_DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? AW'(RING_DEPTH - 1) : s - AW'(1);
  endfunction

  twrl_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] newest_q, newest_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] kept_q, kept_d;
  logic          rd_vld_q, rd_vld_d;
  logic          done_q, done_d;
  logic          granted_q, granted_d;
  logic [TW-1:0] now_q, now_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] wr_q, wr_d;

  logic [TW-1:0] age;
  logic          keep, recent;
  logic          purge_issue, purge_end;
  logic          min_hit, sec_hit, scan_end;
  logic          req_accept;
  logic [CW-1:0] back_cnt;
  logic [CW:0]   oldest_sum;
  logic [AW-1:0] oldest;
  logic [AW-1:0] ins_slot;

  assign age         = now_q - ram_rdata_i;
  assign keep        = age <= TW'(MINUTE_MS);
  assign recent      = age <= TW'(SECOND_MS);
  assign purge_issue = idx_q < count_q;
  assign purge_end   = !purge_issue && !rd_vld_q;
  assign min_hit     = (LW'(count_q) >= LW'(limits_i.min_lim)) ||
                       (count_q == CW'(RING_DEPTH));
  assign sec_hit     = LW'(idx_q) >= LW'(limits_i.sec_lim);
  assign scan_end    = (idx_q == count_q) || (rd_vld_q && !recent);
  assign req_accept  = start_i && (op_i == twrl_pkg::OP_REQUEST);

  // oldest slot lies count - 1 places before the newest one
  assign back_cnt   = count_q - CW'(1);
  assign oldest_sum = (CW+1)'(newest_q) + (CW+1)'(RING_DEPTH) - (CW+1)'(back_cnt);
  assign oldest     = (oldest_sum >= (CW+1)'(RING_DEPTH)) ?
                      AW'(oldest_sum - (CW+1)'(RING_DEPTH)) : AW'(oldest_sum);
  assign ins_slot   = (count_q == '0) ? newest_q : slot_inc(newest_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      twrl_pkg::ST_IDLE: begin
        if (req_accept) begin
          state_d = (count_q == '0) ? twrl_pkg::ST_CHECK : twrl_pkg::ST_PURGE;
        end
      end
      twrl_pkg::ST_PURGE: begin
        if (purge_end) begin
          state_d = twrl_pkg::ST_CHECK;
        end
      end
      twrl_pkg::ST_CHECK: begin
        state_d = min_hit ? twrl_pkg::ST_IDLE : twrl_pkg::ST_COUNT;
      end
      twrl_pkg::ST_COUNT: begin
        if (sec_hit || scan_end) begin
          state_d = twrl_pkg::ST_IDLE;
        end
      end
      default: state_d = twrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    newest_d    = newest_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    rd_vld_d    = 1'b0;
    done_d      = 1'b0;
    granted_d   = 1'b0;
    now_d       = now_q;
    rd_addr_d   = rd_addr_q;
    wr_d        = wr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wr_q;
    ram_wdata_o = ram_rdata_i;
    unique case (state_q)
      twrl_pkg::ST_IDLE: begin
        if (start_i && (op_i == twrl_pkg::OP_CLEAR)) begin
          count_d  = '0;
          newest_d = '0;
          done_d   = 1'b1;
        end else if (req_accept) begin
          now_d     = now_ms_i;
          idx_d     = '0;
          kept_d    = '0;
          rd_addr_d = oldest;
          wr_d      = oldest;
        end
      end
      twrl_pkg::ST_PURGE: begin
        // read oldest to newest, compact the live stamps down to wr
        if (purge_issue) begin
          rd_addr_d = slot_inc(rd_addr_q);
          idx_d     = idx_q + CW'(1);
          rd_vld_d  = 1'b1;
        end
        if (rd_vld_q && keep) begin
          ram_we_o = 1'b1;
          wr_d     = slot_inc(wr_q);
          kept_d   = kept_q + CW'(1);
        end
        if (purge_end) begin
          count_d  = kept_q;
          newest_d = slot_dec(wr_q);
        end
      end
      twrl_pkg::ST_CHECK: begin
        if (min_hit) begin
          done_d = 1'b1;
        end else begin
          idx_d     = '0;
          rd_addr_d = newest_q;
        end
      end
      twrl_pkg::ST_COUNT: begin
        // walk back from the newest stamp, one read in flight ahead
        if (sec_hit) begin
          done_d = 1'b1;
        end else if (scan_end) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = ins_slot;
          ram_wdata_o = now_q;
          newest_d    = ins_slot;
          count_d     = count_q + CW'(1);
          done_d      = 1'b1;
          granted_d   = 1'b1;
        end else begin
          if (rd_vld_q) begin
            idx_d = idx_q + CW'(1);
          end
          rd_addr_d = slot_dec(rd_addr_q);
          rd_vld_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= twrl_pkg::ST_IDLE;
      count_q   <= '0;
      newest_q  <= '0;
      idx_q     <= '0;
      kept_q    <= '0;
      rd_vld_q  <= 1'b0;
      done_q    <= 1'b0;
      granted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      newest_q  <= newest_d;
      idx_q     <= idx_d;
      kept_q    <= kept_d;
      rd_vld_q  <= rd_vld_d;
      done_q    <= done_d;
      granted_q <= granted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    rd_addr_q <= rd_addr_d;
    wr_q      <= wr_d;
  end

  assign ram_raddr_o = rd_addr_q;
  assign busy_o      = state_q != twrl_pkg::ST_IDLE;
  assign done_o      = done_q;
  assign granted_o   = granted_q;

endmodule

>>> src/two_window_rate_limiter.sv
// Two-window rate limiter: a sliding-window log of granted request times.
//
// Input channel: an item (op_i, now_ms_i) is taken at a rising edge with
// start_i high and busy_o low. op_i = 0 asks for a grant at time now_ms_i
// (milliseconds, non-decreasing, wrapping at 2^32); op_i = 1 clears the log.
// Result channel: done_o is high for exactly one cycle with granted_o; the
// receiver cannot stall it, so take it in that cycle.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 second limit, 1 minute limit); other indexes are ignored. Write only
// while busy_o is low and no result is pending.
//
// Order of work: a clear returns its result in the next cycle. A request
// first purges stamps older than MINUTE_MS through the single read port of
// the stamp RAM, then does the minute check and, unless it refuses there,
// counts stamps newer than SECOND_MS from the newest back.
// One item is in work at a time; the next may start while a result shows.
// Reset empties the log and loads the limits 8 and 64; no clearing pass.
module two_window_rate_limiter #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned SECOND_MS  = 1000,
  parameter int unsigned MINUTE_MS  = 60000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                op_i,
  input  logic [twrl_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                done_o,
  output logic                                granted_o,
  input  logic                                cfg_we_i,
  input  logic [twrl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [twrl_pkg::LIMIT_W-1:0]        cfg_wdata_i
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  twrl_pkg::limits_t limits_q;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [twrl_pkg::TIME_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [twrl_pkg::TIME_W-1:0] ram_rdata;

  // Limit registers: hold the value as written, all seven bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.sec_lim <= twrl_pkg::SECOND_LIMIT_RST;
      limits_q.min_lim <= twrl_pkg::MINUTE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        twrl_pkg::REG_SECOND_LIMIT: limits_q.sec_lim <= cfg_wdata_i;
        twrl_pkg::REG_MINUTE_LIMIT: limits_q.min_lim <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer: purge, minute check, recent count, then record the grant.
  twrl_seq #(
    .RING_DEPTH (RING_DEPTH),
    .SECOND_MS  (SECOND_MS),
    .MINUTE_MS  (MINUTE_MS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .now_ms_i    (now_ms_i),
    .limits_i    (limits_q),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .granted_o   (granted_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Stamp ring: one write and one registered read per cycle.
  twrl_ram #(
    .WIDTH (twrl_pkg::TIME_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> src/twrl_checker.sv
module twrl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic op_i,
  input logic done_o,
  input logic granted_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  // a clear answers in the next cycle and never grants
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == twrl_pkg::OP_CLEAR) |=> done_o && !granted_o)
    else $error("clear item gave no refused result in the next cycle");

  // a request is still busy, with no result, in the cycle after it is taken
  a_request_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == twrl_pkg::OP_REQUEST) |=> busy_o && !done_o)
    else $error("request item did not go busy");

  // ending a request shows its result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  a_grant_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    granted_o |-> done_o)
    else $error("granted high without result strobe");

endmodule

bind two_window_rate_limiter twrl_checker u_twrl_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

  // Block geometry and windows, as the RTL is built by default.
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned SECOND_MS  = 1000;
  localparam int unsigned MINUTE_MS  = 60000;

  // Register indexes past the two real limits; writes there must be dropped.
  localparam logic [twrl_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [twrl_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned NUM_PHASES  = 9;
  // Wait a little past the longest request at the end.
  localparam int unsigned DRAIN_CYCLES = 150;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start_i;
  logic                                busy_o;
  logic                                op_i;
  logic [twrl_pkg::TIME_W-1:0]         now_ms_i;
  logic                                done_o;
  logic                                granted_o;
  logic                                cfg_we_i;
  logic [twrl_pkg::CFG_IDX_W-1:0]      cfg_idx_i;
  logic [twrl_pkg::LIMIT_W-1:0]        cfg_wdata_i;

  two_window_rate_limiter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .op_i        (op_i),
    .now_ms_i    (now_ms_i),
    .done_o      (done_o),
    .granted_o   (granted_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Grant predictor plus the queue of grants still owed by the block.
  // Keep its own stamp log, newest slot, stamp count and both limits.
  class grant_scoreboard;
    logic [twrl_pkg::TIME_W-1:0]  stamp_log [RING_DEPTH];
    logic [SLOT_W-1:0]            newest_slot;
    logic [twrl_pkg::LIMIT_W-1:0] held;
    logic [twrl_pkg::LIMIT_W-1:0] sec_lim;
    logic [twrl_pkg::LIMIT_W-1:0] min_lim;
    logic                         grant_q[$];
    int unsigned                  mismatches;

    function new();
      held        = '0;
      newest_slot = '0;
      sec_lim     = twrl_pkg::SECOND_LIMIT_RST;
      min_lim     = twrl_pkg::MINUTE_LIMIT_RST;
      mismatches  = 0;
    endfunction

    function void set_limit(logic [twrl_pkg::CFG_IDX_W-1:0] idx,
                            logic [twrl_pkg::LIMIT_W-1:0] val);
      if (idx == twrl_pkg::REG_SECOND_LIMIT) begin
        sec_lim = val;
      end else if (idx == twrl_pkg::REG_MINUTE_LIMIT) begin
        min_lim = val;
      end
    endfunction

    // Compact the log in place, oldest first, keeping stamps at most a minute
    // old. Time running backwards makes the age wrap huge, so those go too.
    function void drop_expired(logic [twrl_pkg::TIME_W-1:0] now);
      int unsigned                 n;
      logic [SLOT_W-1:0]           oldest;
      logic [SLOT_W-1:0]           wr;
      logic [SLOT_W-1:0]           rd;
      int unsigned                 kept;
      logic [twrl_pkg::TIME_W-1:0] age;
      n = 32'(held);
      if (n == 0) return;
      oldest = SLOT_W'((newest_slot + RING_DEPTH - (n - 1)) % RING_DEPTH);
      wr     = oldest;
      kept   = 0;
      for (int unsigned i = 0; i < n; i++) begin
        rd  = SLOT_W'((oldest + i) % RING_DEPTH);
        age = now - stamp_log[rd];
        if (age <= MINUTE_MS) begin
          stamp_log[wr] = stamp_log[rd];
          wr = SLOT_W'((wr + 1) % RING_DEPTH);
          kept++;
        end
      end
      held        = twrl_pkg::LIMIT_W'(kept);
      newest_slot = SLOT_W'((wr + RING_DEPTH - 1) % RING_DEPTH);
    endfunction

    // Count back from the newest stamp while stamps are at most a second old.
    function int unsigned recent_run(logic [twrl_pkg::TIME_W-1:0] now);
      int unsigned                 c;
      logic [twrl_pkg::TIME_W-1:0] age;
      c = 0;
      while (c < held) begin
        age = now - stamp_log[SLOT_W'((newest_slot + RING_DEPTH - c) % RING_DEPTH)];
        if (age > SECOND_MS) break;
        c++;
      end
      return c;
    endfunction

    function logic admit_request(logic [twrl_pkg::TIME_W-1:0] now);
      drop_expired(now);
      // Full ring refuses regardless of the minute limit.
      if (held >= min_lim || held >= RING_DEPTH) return 1'b0;
      if (recent_run(now) >= sec_lim) return 1'b0;
      // An empty log reuses its current slot; otherwise advance one.
      if (held != 0) newest_slot = newest_slot + 1'b1;
      stamp_log[newest_slot] = now;
      held = held + 1'b1;
      return 1'b1;
    endfunction

    function void note_item(logic op, logic [twrl_pkg::TIME_W-1:0] now);
      if (op == twrl_pkg::OP_CLEAR) begin
        held        = '0;
        newest_slot = '0;
        grant_q.push_back(1'b0);
      end else begin
        grant_q.push_back(admit_request(now));
      end
    endfunction

    function void check_grant(logic got);
      logic want;
      if (grant_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: unexpected result, expected none, got granted_o=%0b",
                   $realtime, got);
        end
        mismatches++;
        return;
      end
      want = grant_q.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("%0t: granted_o mismatch, expected %0b, got %0b",
                   $realtime, want, got);
        end
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return grant_q.size();
    endfunction
  endclass

  typedef struct {
    logic [twrl_pkg::LIMIT_W-1:0] sec;
    logic [twrl_pkg::LIMIT_W-1:0] min;
    bit                           fast;   // tiny time steps, to fill the ring
    bit                           idle;   // allow sender gaps
  } phase_t;

  grant_scoreboard sb;
  phase_t          phases [NUM_PHASES];

  // 10 ns clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result channel cannot be stalled: check every strobe as it shows.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_grant(granted_o);
    end
  end

  // Hold start and the item until the block takes it. Optionally drop start
  // for a burst first so gaps land anywhere in the block's work.
  task automatic send_item(input logic op, input logic [twrl_pkg::TIME_W-1:0] now,
                           input bit may_idle);
    int unsigned gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk_i);
    end
    start_i  = 1'b1;
    op_i     = op;
    now_ms_i = now;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(op, now);
    @(negedge clk_i);
  endtask

  // Drop start and wait until every owed result has come back.
  task automatic drain();
    start_i = 1'b0;
    while (sb.pending() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [twrl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [twrl_pkg::LIMIT_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_limit(idx, val);
  endtask

  // Pick the next request time: mostly small forward steps, some steps
  // near the one-second and one-minute edges, rare big jumps and rare
  // steps backwards.
  function automatic logic [twrl_pkg::TIME_W-1:0] next_time(
      logic [twrl_pkg::TIME_W-1:0] t, bit fast);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (fast && pick < 90) return t + $urandom_range(0, 10);
    if (pick < 50) return t + $urandom_range(0, 150);
    if (pick < 62) return t;
    if (pick < 72) return t + $urandom_range(SECOND_MS - 100, SECOND_MS + 100);
    if (pick < 80) return t + $urandom_range(MINUTE_MS - 100, MINUTE_MS + 100);
    if (pick < 90) return t + $urandom_range(0, 3000);
    if (pick < 95) return t + $urandom;
    return t - $urandom_range(1, 70000);
  endfunction

  initial begin
    logic [twrl_pkg::TIME_W-1:0] t;
    logic                        op;

    sb          = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    op_i        = twrl_pkg::OP_REQUEST;
    now_ms_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = twrl_pkg::REG_SECOND_LIMIT;
    cfg_wdata_i = '0;

    // Zero limits, full ring, odd and top-of-range settings, defaults last.
    phases[0] = '{sec: 7'd0,   min: 7'd64,  fast: 1'b0, idle: 1'b1};
    phases[1] = '{sec: 7'd8,   min: 7'd0,   fast: 1'b0, idle: 1'b1};
    phases[2] = '{sec: 7'd127, min: 7'd127, fast: 1'b1, idle: 1'b1};
    phases[3] = '{sec: 7'd64,  min: 7'd64,  fast: 1'b1, idle: 1'b1};
    phases[4] = '{sec: 7'd1,   min: 7'd1,   fast: 1'b0, idle: 1'b1};
    phases[5] = '{sec: 7'd3,   min: 7'd10,  fast: 1'b0, idle: 1'b1};
    phases[6] = '{sec: 7'd100, min: 7'd5,   fast: 1'b1, idle: 1'b1};
    phases[7] = '{sec: 7'($urandom_range(0, 127)), min: 7'($urandom_range(0, 127)),
                  fast: 1'b0, idle: 1'b1};
    phases[8] = '{sec: twrl_pkg::SECOND_LIMIT_RST, min: twrl_pkg::MINUTE_LIMIT_RST,
                  fast: 1'b0, idle: 1'b0};

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at reset limits (8 per second, 64 per minute).
    send_item(twrl_pkg::OP_CLEAR,   32'd0,          1'b0);
    send_item(twrl_pkg::OP_REQUEST, 32'hFFFF_FFFF,  1'b0);
    send_item(twrl_pkg::OP_REQUEST, 32'd0,          1'b0);  // wrap, age one
    send_item(twrl_pkg::OP_REQUEST, 32'd998,        1'b0);
    send_item(twrl_pkg::OP_REQUEST, 32'd999,        1'b0);  // oldest exactly one second old
    send_item(twrl_pkg::OP_REQUEST, 32'd1000,       1'b0);  // oldest just past one second
    repeat (5) send_item(twrl_pkg::OP_REQUEST, 32'd1000, 1'b0);  // run into the second limit
    send_item(twrl_pkg::OP_REQUEST, 32'd60999,      1'b0);  // stamps on both sides of a minute
    send_item(twrl_pkg::OP_REQUEST, 32'd61000,      1'b0);
    send_item(twrl_pkg::OP_REQUEST, 32'd500,        1'b0);  // time going backwards
    send_item(twrl_pkg::OP_REQUEST, 32'd500,        1'b0);
    send_item(twrl_pkg::OP_CLEAR,   32'hFFFF_FFFF,  1'b0);
    send_item(twrl_pkg::OP_REQUEST, 32'hFFFF_FFFF,  1'b0);
    send_item(twrl_pkg::OP_REQUEST, 32'h5555_5555,  1'b0);
    send_item(twrl_pkg::OP_REQUEST, 32'hAAAA_AAAA,  1'b0);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      drain();
      // Spare indexes must leave both limits alone.
      write_reg(REG_SPARE_2, 7'($urandom));
      write_reg(REG_SPARE_3, 7'($urandom));
      write_reg(twrl_pkg::REG_SECOND_LIMIT, phases[p].sec);
      write_reg(twrl_pkg::REG_MINUTE_LIMIT, phases[p].min);
      // Start some phases just short of the 32-bit wrap, the rest anywhere.
      t = (p % 3 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        op = ($urandom_range(0, 39) == 0) ? twrl_pkg::OP_CLEAR : twrl_pkg::OP_REQUEST;
        t  = next_time(t, phases[p].fast);
        send_item(op, t, phases[p].idle);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("two_window_rate_limiter test passed");
    end else begin
      $display("two_window_rate_limiter test failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(10_000_000);
    $display("two_window_rate_limiter test failed");
    $finish;
  end

endmodule
